/* hw/rtl/tcrc_pkg.sv */
// Shared types and constants for the two-choice replacement cache.
`timescale 1ns / 1ps
package tcrc_pkg;

  localparam int unsigned KEY_W         = 64;
  localparam int unsigned NAME_W        = 32;
  localparam int unsigned CAP_W         = 9;
  localparam int unsigned PICK_W        = 8;
  localparam int unsigned SLOTS_DEFAULT = 256;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    KIND_LOOKUP  = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_REPLACE = 2'd2
  } kind_t;

  // count: fill level for a lookup scan, write slot for an append
  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
    logic [CAP_W-1:0] count;
    logic [CAP_W-1:0] slot_a;
    logic [CAP_W-1:0] slot_b;
    logic             tie_bit;
    logic             is_full;
  } cmd_t;

endpackage

/* hw/rtl/tcrc_ifs.sv */
// Handshake interfaces for request, response and configuration words.
`timescale 1ns / 1ps
interface tcrc_req_if;
  import tcrc_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [KEY_W-1:0]  chunk_key;
  logic [PICK_W-1:0] pick_a;
  logic [PICK_W-1:0] pick_b;
  logic              tie_bit;
  modport source (output valid, operation, chunk_key, pick_a, pick_b, tie_bit, input ready);
  modport sink (input valid, operation, chunk_key, pick_a, pick_b, tie_bit, output ready);
endinterface

interface tcrc_rsp_if;
  import tcrc_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic             is_full;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  modport source (output valid, hit, is_full, evicted, evicted_key, input ready);
  modport sink (input valid, hit, is_full, evicted, evicted_key, output ready);
endinterface

interface tcrc_cfg_if;
  import tcrc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/tcrc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcrc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/tcrc_front.sv */
// Front end: capacity register, fill counter and classification of request words.
`timescale 1ns / 1ps
module tcrc_front #(
  parameter int unsigned SLOTS = tcrc_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  tcrc_req_if.sink       req,
  tcrc_cfg_if.sink       cfg,
  output logic           push_valid,
  input  logic           push_ready,
  output tcrc_pkg::cmd_t push_cmd
);
  import tcrc_pkg::*;

  localparam int unsigned CAP_LIMIT = (SLOTS > (1 << CAP_W) - 1) ? (1 << CAP_W) - 1 : SLOTS;
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(CAP_LIMIT);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(SLOTS % (1 << CAP_W));

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] fill_count;
  logic [CAP_W-1:0] fill_count_next;
  logic [CAP_W-1:0] eff_cap;
  logic             full;
  logic             accept;
  kind_t            kind;

  function automatic logic [CAP_W-1:0] clamp_pick(logic [PICK_W-1:0] pick,
                                                  logic [CAP_W-1:0] fill);
    logic [CAP_W-1:0] p;
    p = CAP_W'(pick);
    return (p >= fill) ? fill - 1'b1 : p;
  endfunction

  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (capacity > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end
  end

  assign full = fill_count >= eff_cap;

  always_comb begin
    kind            = KIND_LOOKUP;
    fill_count_next = fill_count;
    if (req.operation) begin
      if (full) begin
        kind = KIND_REPLACE;
      end else begin
        kind            = KIND_APPEND;
        fill_count_next = fill_count + 1'b1;
      end
    end
  end

  assign req.ready  = push_ready;
  assign push_valid = req.valid;
  assign accept     = req.valid && push_ready;
  assign cfg.ready  = 1'b1;

  always_comb begin
    push_cmd.kind    = kind;
    push_cmd.key     = req.chunk_key;
    push_cmd.count   = fill_count;
    push_cmd.slot_a  = clamp_pick(req.pick_a, fill_count);
    push_cmd.slot_b  = clamp_pick(req.pick_b, fill_count);
    push_cmd.tie_bit = req.tie_bit;
    push_cmd.is_full = fill_count_next >= eff_cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      fill_count <= '0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      if (accept) begin
        fill_count <= fill_count_next;
      end
    end
  end

endmodule

/* hw/rtl/tcrc_queue.sv */
// Short command queue between front end and back end.
`timescale 1ns / 1ps
module tcrc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tcrc_pkg::cmd_t push_cmd,
  output logic           head_valid,
  output tcrc_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import tcrc_pkg::*;

  // depth is a power of two, pointers wrap naturally
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/tcrc_back.sv */
// Back end: slot memory, lookup scan, append and two-choice replacement.
`timescale 1ns / 1ps
module tcrc_back #(
  parameter int unsigned SLOTS = tcrc_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tcrc_pkg::cmd_t head_cmd,
  output logic           pop,
  tcrc_rsp_if.source     rsp
);
  import tcrc_pkg::*;

  localparam int unsigned ADDR_W = $clog2(SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_RD_A = 4'b0100,
    ST_RD_B = 4'b1000
  } state_t;

  state_t           state;
  cmd_t             cur;
  logic [CAP_W-1:0] idx;
  logic [KEY_W-1:0] key_a;

  logic             res_valid;
  logic             res_hit;
  logic             res_full;
  logic             res_ev;
  logic [KEY_W-1:0] res_key;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_data;

  logic [NAME_W-1:0] name_a;
  logic [NAME_W-1:0] name_b;
  logic              take_b;
  logic [CAP_W-1:0]  victim;
  logic [KEY_W-1:0]  victim_key;

  tcrc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pop = (state == ST_IDLE) && head_valid && !res_valid;

  assign name_a     = key_a[KEY_W-1 -: NAME_W];
  assign name_b     = rd_data[KEY_W-1 -: NAME_W];
  assign take_b     = (name_a > name_b) || ((name_a == name_b) && cur.tie_bit);
  assign victim     = take_b ? cur.slot_b : cur.slot_a;
  assign victim_key = take_b ? rd_data : key_a;

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cur.key;
    unique case (state)
      ST_IDLE: begin
        rd_addr = ADDR_W'(head_cmd.slot_a);
        if (pop && head_cmd.kind == KIND_APPEND) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(head_cmd.count);
          wr_data = head_cmd.key;
        end
      end
      ST_SCAN: rd_addr = ADDR_W'(idx + 1'b1);
      ST_RD_A: rd_addr = ADDR_W'(cur.slot_b);
      ST_RD_B: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(victim);
      end
      default: rd_addr = '0;
    endcase
    // lookup starts its scan at slot zero
    if (state == ST_IDLE && head_cmd.kind == KIND_LOOKUP) begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end
    if (state == ST_RD_A) begin
      key_a <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            res_hit  <= 1'b0;
            res_ev   <= 1'b0;
            res_key  <= '0;
            res_full <= head_cmd.is_full;
            unique case (head_cmd.kind)
              KIND_LOOKUP: begin
                if (head_cmd.count == '0) begin
                  res_valid <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= ST_SCAN;
                end
              end
              KIND_APPEND:  res_valid <= 1'b1;
              KIND_REPLACE: state <= ST_RD_A;
              default:      res_valid <= 1'b1;
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_data == cur.key) begin
            res_hit   <= 1'b1;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (idx + 1'b1 == cur.count) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_RD_A: state <= ST_RD_B;
        ST_RD_B: begin
          res_ev    <= 1'b1;
          res_key   <= victim_key;
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.hit         = res_hit;
  assign rsp.is_full     = res_full;
  assign rsp.evicted     = res_ev;
  assign rsp.evicted_key = res_key;

endmodule

/* hw/rtl/two_choice_replacement_cache_unit.sv */
// Top level of the two-choice replacement cache.
`timescale 1ns / 1ps
// Keyed store of SLOTS 64-bit chunk keys with one response word per request word.
// The front end classifies each request (lookup, append or replacement) and
// updates the fill count at once, so up to two requests wait in the command
// queue while the back end works. In the back end, whose slot memory has a
// single read port, an append writes its slot when the command is taken, a
// replacement reads the two candidate slots one after the other and then writes
// the victim slot, and a lookup reads slots from zero until a hit or until it
// has scanned the fill count. A response waiting on rsp holds the back end but
// not the front end until the command queue is full. The capacity register may
// be written at any time the block is idle; cfg.ready is always high.
module two_choice_replacement_cache_unit #(
  parameter int unsigned SLOTS = tcrc_pkg::SLOTS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  tcrc_req_if.sink   req,
  tcrc_rsp_if.source rsp,
  tcrc_cfg_if.sink   cfg
);
  import tcrc_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  tcrc_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tcrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  tcrc_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

/* hw/rtl/tcrc_checker.sv */
// Port-level checks on the cache top level, bound to every instance.
`timescale 1ns / 1ps
module tcrc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       hit,
  input logic                       is_full,
  input logic                       evicted,
  input logic [tcrc_pkg::KEY_W-1:0] evicted_key
);
  import tcrc_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(hit) && $stable(evicted) && $stable(evicted_key))
    else $error("response word changed while stalled");

  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && evicted))
    else $error("hit and eviction in one word");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && evicted |-> is_full)
    else $error("eviction while not full");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !evicted |-> evicted_key == '0)
    else $error("evicted key set without eviction");

endmodule

bind two_choice_replacement_cache_unit tcrc_checker u_tcrc_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .hit         (rsp.hit),
  .is_full     (rsp.is_full),
  .evicted     (rsp.evicted),
  .evicted_key (rsp.evicted_key)
);
